// ===== hdl/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg: shared constants and types for the sorted table search core
// Table depth, derived widths and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int POS_W       = 10;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic accept;     // latch the request and, for an append to a non-full table, write it
        logic issue_read; // read the probe entry at the current midpoint
        logic step;       // narrow the range from the registered probe word
        logic load_out;   // move the finished result into the output register
    } t_cmd;

    typedef struct packed {
        logic range_empty; // first has passed last: the search missed
        logic equal;       // probed word equals the key
        logic less;        // probed word is below the key
    } t_status;

endpackage

// ===== hdl/stbs_datapath.sv =====
// ----------------------------------------------------------------------------
// stbs_datapath: table memory, search range registers and result register
// Holds the word memory, the fill count, the newest word, the search range
// and the output payload. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module stbs_datapath
    import stbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_opcode,
    input  logic [WORD_W-1:0] i_value,
    output t_status           o_status,
    output logic              o_found,
    output logic [POS_W-1:0]  o_position,
    output logic [WORD_W-1:0] o_newest_value,
    output logic              o_overflow
);

    logic [WORD_W-1:0] r_mem [TABLE_DEPTH];

    logic [CNT_W-1:0]  r_count;
    logic [WORD_W-1:0] r_newest;
    logic [WORD_W-1:0] r_key;
    logic [CNT_W-1:0]  r_first;
    logic [CNT_W-1:0]  r_hi;      // one past the last candidate entry
    logic [ADDR_W-1:0] r_mid;
    logic [WORD_W-1:0] r_rdata;
    logic              r_found;
    logic [ADDR_W-1:0] r_hit_pos;
    logic              r_ovf;

    logic [CNT_W:0]    n_sum;
    logic [ADDR_W-1:0] n_mid;
    logic              n_full;
    logic              n_do_write;

    // With first below hi, (first + hi - 1) / 2 is the midpoint of first..last.
    assign n_sum      = {1'b0, r_first} + {1'b0, r_hi} - {{CNT_W{1'b0}}, 1'b1};
    assign n_mid      = n_sum[ADDR_W:1];
    assign n_full     = (r_count == CNT_W'(TABLE_DEPTH));
    assign n_do_write = i_cmd.accept && (i_opcode == OP_APPEND) && !n_full;

    assign o_status.range_empty = (r_first >= r_hi);
    assign o_status.equal       = (r_rdata == r_key);
    assign o_status.less        = (r_rdata < r_key);

    always_ff @(posedge i_clk) begin
        if (n_do_write) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_value;
        end
        if (i_cmd.issue_read) begin
            r_rdata <= r_mem[n_mid];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_newest <= '0;
        end else if (n_do_write) begin
            r_count  <= r_count + 1'b1;
            r_newest <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key     <= i_value;
            r_first   <= '0;
            r_hi      <= r_count;
            r_found   <= 1'b0;
            r_hit_pos <= '0;
            r_ovf     <= (i_opcode == OP_APPEND) && n_full;
        end
        if (i_cmd.issue_read) begin
            r_mid <= n_mid;
        end
        if (i_cmd.step) begin
            if (o_status.equal) begin
                r_found   <= 1'b1;
                r_hit_pos <= r_mid;
                // A hit empties the range so the controller finishes next.
                r_first   <= r_hi;
            end else if (o_status.less) begin
                r_first <= CNT_W'(r_mid) + 1'b1;
            end else begin
                r_hi <= CNT_W'(r_mid);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_found        <= r_found;
            o_position     <= POS_W'(r_hit_pos);
            o_newest_value <= r_newest;
            o_overflow     <= r_ovf;
        end
    end

endmodule

// ===== hdl/stbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// stbs_ctrl: sequencer for appends and binary searches
// Accepts one request at a time, steps the datapath through probe and
// compare cycles, and owns the output valid flag.
// ----------------------------------------------------------------------------
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_opcode,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_DONE
    } t_state;

    t_state r_state;
    logic   n_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign n_load     = (r_state == S_DONE) && (!o_out_valid || i_out_ready);

    assign o_cmd.accept     = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.issue_read = (r_state == S_PROBE) && !i_status.range_empty;
    assign o_cmd.step       = (r_state == S_CMP);
    assign o_cmd.load_out   = n_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (n_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= (i_opcode == OP_SEARCH) ? S_PROBE : S_DONE;
                    end
                end
                S_PROBE: begin
                    r_state <= i_status.range_empty ? S_DONE : S_CMP;
                end
                S_CMP: begin
                    r_state <= S_PROBE;
                end
                S_DONE: begin
                    if (n_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/sorted_table_binary_search_core.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core: appendable word table with binary search
// Each request either appends a word or searches the filled entries for a
// key. Every request yields exactly one result.
//
// Input channel: i_in_valid / o_in_ready with i_opcode and i_value.
// Output channel: o_out_valid / i_out_ready with o_found, o_position,
// o_newest_value and o_overflow, held in an output register.
// One request is in flight at a time; o_in_ready is high while idle.
// An append moves straight from acceptance to S_DONE, where its result is
// loaded once the output register is free. A search makes k probes, at
// most floor(log2(entries)) + 1; each probe reads the memory in S_PROBE and
// compares in S_CMP, and the search then ends in S_DONE like an append.
// The next request can be accepted in the cycle after the result is loaded.
// A request may be accepted while the previous result still waits in the
// output register; its result then waits in the datapath, with the
// controller in S_DONE, until the receiver takes the old one. Appends to a
// full table are dropped and flagged by o_overflow. Reset empties the table
// and clears o_out_valid; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core
    import stbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_opcode,
    input  logic [WORD_W-1:0] i_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_found,
    output logic [POS_W-1:0]  o_position,
    output logic [WORD_W-1:0] o_newest_value,
    output logic              o_overflow
);

    t_cmd    w_cmd;
    t_status w_status;

    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    stbs_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_opcode       (i_opcode),
        .i_value        (i_value),
        .o_status       (w_status),
        .o_found        (o_found),
        .o_position     (o_position),
        .o_newest_value (o_newest_value),
        .o_overflow     (o_overflow)
    );

endmodule

// ===== hdl/stbs_checker.sv =====
// ----------------------------------------------------------------------------
// stbs_checker: port-level assertions for the sorted table search core
// Checks result stability under stall, one request in flight, and the
// consistency of the result flags.
// ----------------------------------------------------------------------------
module stbs_checker
    import stbs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_found,
    input logic [POS_W-1:0]  o_position,
    input logic [WORD_W-1:0] o_newest_value,
    input logic              o_overflow
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found)
            && $stable(o_position) && $stable(o_newest_value)
            && $stable(o_overflow))
        else $error("result changed while stalled");

    // Once a request is taken, o_in_ready falls, so no second request is taken straight behind it.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request accepted in the cycle after acceptance");

    // A hit comes only from a search, which never reports overflow.
    a_hit_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> !o_overflow)
        else $error("hit reported together with overflow");

    // A dropped append reports no hit and position zero.
    a_ovf_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> !o_found && (o_position == '0))
        else $error("overflow result carries search fields");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_found        (o_found),
    .o_position     (o_position),
    .o_newest_value (o_newest_value),
    .o_overflow     (o_overflow)
);

// ===== tb/tb_sorted_table_binary_search_core.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search_core: self-checking bench for the table core
// Appends and searches are sent over the request channel. A local copy of
// the table replays every accepted request to predict its result, and every
// result is compared field by field in order. The table fills from empty,
// through mostly ascending contents with duplicates and stray words, to full
// with dropped appends; both channels stall at random until the fill phase.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search_core;
    import stbs_pkg::*;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] newest_value;
        logic              overflow;
    } t_table_result;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_ready;
    logic              i_opcode       = OP_APPEND;
    logic [WORD_W-1:0] i_value        = '0;
    logic              o_out_valid;
    logic              i_out_ready    = 1'b0;
    logic              o_found;
    logic [POS_W-1:0]  o_position;
    logic [WORD_W-1:0] o_newest_value;
    logic              o_overflow;

    // Local copy of the table, updated at each accepted append.
    logic [WORD_W-1:0] table_words [0:TABLE_DEPTH-1];
    int                table_count = 0;
    logic [WORD_W-1:0] ascending_word = '0;

    t_table_result     awaited_results [$];
    t_table_result     oldest_result;
    int                error_count = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;

    sorted_table_binary_search_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_position     (o_position),
        .o_newest_value (o_newest_value),
        .o_overflow     (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_table_result search_or_append(input logic op,
                                                       input logic [WORD_W-1:0] word);
        t_table_result r;
        int            lo;
        int            hi;
        int            mid;
        r = '0;
        if (op == OP_APPEND) begin
            if (table_count < TABLE_DEPTH) begin
                table_words[table_count] = word;
                table_count++;
            end else begin
                r.overflow = 1'b1;
            end
        end else begin
            lo = 0;
            hi = table_count - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (table_words[mid] < word) begin
                    lo = mid + 1;
                end else if (table_words[mid] == word) begin
                    r.found    = 1'b1;
                    r.position = mid[POS_W-1:0];
                    lo         = hi + 1;
                end else begin
                    hi = mid - 1;
                end
            end
        end
        r.newest_value = (table_count == 0) ? '0 : table_words[table_count-1];
        return r;
    endfunction

    // Mostly ascending words, with some repeats and a few stray words that
    // break the ordering.
    function automatic logic [WORD_W-1:0] next_append_word();
        int unsigned       pick;
        logic [WORD_W-1:0] stride;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return $urandom;
        if (pick < 10)
            return ascending_word;
        stride = $urandom_range(0, 6_000_000);
        if (ascending_word > 32'hFFFF_FFFF - stride)
            ascending_word = 32'hFFFF_FFFF;
        else
            ascending_word = ascending_word + stride;
        return ascending_word;
    endfunction

    function automatic logic [WORD_W-1:0] next_search_key();
        int unsigned pick;
        int unsigned idx;
        pick = $urandom_range(0, 99);
        if (table_count == 0 || pick < 15)
            return $urandom;
        idx = $urandom_range(0, table_count - 1);
        if (pick < 70)
            return table_words[idx];
        if (pick < 80)
            return table_words[idx] + 1'b1;
        if (pick < 90)
            return table_words[idx] - 1'b1;
        if (pick < 95)
            return '0;
        return '1;
    endfunction

    // Valid is only lowered when the sender idles, so a back-to-back request
    // never sees valid dropped and raised in the same step.
    task automatic send_request(input logic op, input logic [WORD_W-1:0] word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_value    <= word;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        awaited_results.push_back(search_or_append(op, word));
    endtask

    task automatic test_empty_table();
        send_request(OP_SEARCH, '0);
        send_request(OP_SEARCH, '1);
    endtask

    task automatic test_small_table();
        send_request(OP_APPEND, '0);
        send_request(OP_APPEND, '0);
        send_request(OP_SEARCH, '0);
        send_request(OP_APPEND, 32'd7);
        send_request(OP_APPEND, 32'd3);
        send_request(OP_SEARCH, 32'd3);
        send_request(OP_SEARCH, 32'd7);
        send_request(OP_SEARCH, 32'd5);
        send_request(OP_SEARCH, '1);
        send_request(OP_APPEND, 32'd16);
        send_request(OP_SEARCH, 32'd16);
        ascending_word = 32'd16;
    endtask

    task automatic test_random_mix(input int n_requests, input int append_pct);
        repeat (n_requests) begin
            if ($urandom_range(0, 99) < append_pct)
                send_request(OP_APPEND, next_append_word());
            else
                send_request(OP_SEARCH, next_search_key());
        end
    endtask

    task automatic test_fill_table();
        while (table_count < TABLE_DEPTH)
            test_random_mix(1, 75);
    endtask

    task automatic test_full_table();
        send_request(OP_APPEND, '1);
        send_request(OP_APPEND, '0);
        send_request(OP_SEARCH, table_words[TABLE_DEPTH-1]);
        send_request(OP_SEARCH, table_words[0]);
        send_request(OP_SEARCH, table_words[TABLE_DEPTH/2]);
        send_request(OP_SEARCH, '1);
        test_random_mix(300, 40);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                oldest_result = awaited_results.pop_front();
                if (o_found !== oldest_result.found) begin
                    $error("found: expected %0d, actual %0d", oldest_result.found, o_found);
                    error_count++;
                end
                if (o_position !== oldest_result.position) begin
                    $error("position: expected %0d, actual %0d",
                           oldest_result.position, o_position);
                    error_count++;
                end
                if (o_newest_value !== oldest_result.newest_value) begin
                    $error("newest_value: expected %h, actual %h",
                           oldest_result.newest_value, o_newest_value);
                    error_count++;
                end
                if (o_overflow !== oldest_result.overflow) begin
                    $error("overflow: expected %0d, actual %0d",
                           oldest_result.overflow, o_overflow);
                    error_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 9;
        recv_idle_pct = 61;
        test_empty_table();
        test_small_table();
        test_random_mix(600, 55);

        send_idle_pct = 61;
        recv_idle_pct = 9;
        test_random_mix(600, 55);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_fill_table();
        test_full_table();

        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        // Let any stray result show up before the verdict.
        repeat (40) @(posedge i_clk);
        if (error_count == 0)
            $display("** sorted_table_binary_search_core: PASSED **");
        else
            $display("** sorted_table_binary_search_core: FAILED **");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("** sorted_table_binary_search_core: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/stbs_pkg.sv
hdl/stbs_datapath.sv
hdl/stbs_ctrl.sv
hdl/sorted_table_binary_search_core.sv
hdl/stbs_checker.sv
tb/tb_sorted_table_binary_search_core.sv
